// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl, empty when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition holds at every clock edge outside reset
`define PASS_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("pass assertion failed");

// consequent holds in the cycle after the antecedent
`define PASS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pass assertion failed");

`else

`define PASS_ASSERT(lbl, clk, rst, expr)
`define PASS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/pass_pkg.sv -----
`default_nettype none

package pass_pkg;

   localparam int SLOT_COUNT     = 16;
   localparam int PAYLOAD_BYTES  = 64;
   localparam int SLOT_W         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int IDX_W          = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int ADDR_W         = (SLOT_COUNT * PAYLOAD_BYTES > 1) ?
                                   $clog2(SLOT_COUNT * PAYLOAD_BYTES) : 1;
   localparam int OP_W           = 2;
   localparam int BYTE_W         = 8;
   localparam int REQ_LEN_W      = 16;
   localparam int STATUS_W       = 2;
   localparam int LEN_W          = 7;
   localparam int COUNT_W        = 5;
   localparam int CMD_FIFO_DEPTH = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_PAYLOAD = 2'd1,
      OP_DEQUEUE = 2'd2,
      OP_COUNT   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      CMD_RESULT = 1'b0,
      CMD_STREAM = 1'b1
   } cmd_kind_type;

   // work handed from the front to the back
   typedef struct packed {
      cmd_kind_type               kind;
      status_type                 status;
      logic [BYTE_W-1:0]          action_type;
      logic [LEN_W-1:0]           length;
      logic [LEN_W-1:0]           written;
      logic [SLOT_W-1:0]          slot;
      logic [COUNT_W-1:0]         used_count;
   } cmd_type;

   typedef struct packed {
      status_type                 status;
      logic [BYTE_W-1:0]          action_type_res;
      logic [LEN_W-1:0]           length_res;
      logic [BYTE_W-1:0]          data_byte_res;
      logic                       byte_valid;
      logic [COUNT_W-1:0]         used_count;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      logic                       stream_done;
   } back_status_type;

   function automatic logic [ADDR_W-1:0] payload_addr(input logic [SLOT_W-1:0] slot,
                                                      input logic [IDX_W-1:0] pos);
      return ADDR_W'(slot) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(pos);
   endfunction

endpackage

`default_nettype wire

// ----- src/pass_chan_if.sv -----
`default_nettype none

interface pass_req_if import pass_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [BYTE_W-1:0]    action_type;
   logic [REQ_LEN_W-1:0] length;
   logic [BYTE_W-1:0]    data_byte;

   modport source (output valid, operation, action_type, length, data_byte,
                   input ready);
   modport sink   (input valid, operation, action_type, length, data_byte,
                   output ready);
endinterface

interface pass_rsp_if import pass_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [BYTE_W-1:0]    action_type_res;
   logic [LEN_W-1:0]     length_res;
   logic [BYTE_W-1:0]    data_byte_res;
   logic                 byte_valid;
   logic [COUNT_W-1:0]   used_count;
   logic                 last;

   modport source (output valid, status, action_type_res, length_res, data_byte_res,
                   byte_valid, used_count, last, input ready);
   modport sink   (input valid, status, action_type_res, length_res, data_byte_res,
                   byte_valid, used_count, last, output ready);
endinterface

`default_nettype wire

// ----- src/pass_ram.sv -----
`default_nettype none

module pass_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/pass_cmd_fifo.sv -----
`default_nettype none
`include "assert_macros.svh"

module pass_cmd_fifo import pass_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    space,
   output logic    valid,
   output cmd_type data,
   input  logic    pop
);

   localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type            mem_ff [CMD_FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign space = count_ff < CNT_W'(CMD_FIFO_DEPTH);
   assign valid = count_ff != '0;
   assign data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PASS_ASSERT(a_fifo_no_overflow, clock, reset, !(push && count_ff == CNT_W'(CMD_FIFO_DEPTH)))
   `PASS_ASSERT(a_fifo_no_underflow, clock, reset, !(pop && count_ff == '0))

endmodule

`default_nettype wire

// ----- src/pass_front.sv -----
`default_nettype none
`include "assert_macros.svh"

module pass_front import pass_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pass_req_if.sink          req_bus,
   output logic              cmd_push,
   output cmd_type           cmd_data,
   input  logic              cmd_space,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [BYTE_W-1:0] ram_wr_data,
   input  back_status_type   back_status
);

   localparam int INFL_W = $clog2(CMD_FIFO_DEPTH + 2);

   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic [BYTE_W-1:0]     type_ff [SLOT_COUNT];
   logic [BYTE_W-1:0]     type_in [SLOT_COUNT];
   logic [LEN_W-1:0]      len_ff  [SLOT_COUNT];
   logic [LEN_W-1:0]      len_in  [SLOT_COUNT];
   // bytes ever written per slot since reset, always a prefix
   logic [LEN_W-1:0]      hw_ff   [SLOT_COUNT];
   logic [LEN_W-1:0]      hw_in   [SLOT_COUNT];
   logic [COUNT_W-1:0]    used_count_ff, used_count_in;
   logic [SLOT_W-1:0]     fill_slot_ff, fill_slot_in;
   logic [LEN_W-1:0]      fill_pos_ff, fill_pos_in;
   logic [LEN_W-1:0]      fill_len_ff, fill_len_in;
   logic [LEN_W-1:0]      fill_hw_ff, fill_hw_in;
   logic                  fill_active_ff, fill_active_in;
   logic [INFL_W-1:0]     inflight_ff, inflight_in;

   op_type                op;
   logic                  accept;
   logic                  free_found, used_found;
   logic [SLOT_W-1:0]     free_idx, used_idx, meta_slot;
   logic [LEN_W-1:0]      hw_rd, clamped, pos_next;
   logic                  stream_push;

   assign op = op_type'(req_bus.operation);

   // lowest free and lowest used slot
   always_comb begin
      free_found = 1'b0;
      used_found = 1'b0;
      free_idx   = '0;
      used_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
         if (used_ff[i]) begin
            used_found = 1'b1;
            used_idx   = SLOT_W'(i);
         end
      end
   end

   assign meta_slot = (op == OP_ENQUEUE) ? free_idx : used_idx;
   assign hw_rd     = hw_ff[meta_slot];
   assign clamped   = (req_bus.length > REQ_LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES)
                                                                   : req_bus.length[LEN_W-1:0];
   assign pos_next  = fill_pos_ff + LEN_W'(1);

   // payload writes wait while a dequeue may still read the ram
   always_comb begin
      unique case (op)
         OP_PAYLOAD: req_bus.ready = !(fill_active_ff && inflight_ff != '0);
         OP_ENQUEUE,
         OP_DEQUEUE,
         OP_COUNT:   req_bus.ready = cmd_space;
         default:    req_bus.ready = 1'b0;
      endcase
   end

   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      used_in        = used_ff;
      type_in        = type_ff;
      len_in         = len_ff;
      hw_in          = hw_ff;
      used_count_in  = used_count_ff;
      fill_slot_in   = fill_slot_ff;
      fill_pos_in    = fill_pos_ff;
      fill_len_in    = fill_len_ff;
      fill_hw_in     = fill_hw_ff;
      fill_active_in = fill_active_ff;
      cmd_push       = 1'b0;
      cmd_data       = '0;
      stream_push    = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = payload_addr(fill_slot_ff, fill_pos_ff[IDX_W-1:0]);
      ram_wr_data    = req_bus.data_byte;

      if (accept) begin
         unique case (op)
            OP_ENQUEUE: begin
               cmd_push = 1'b1;
               if (free_found) begin
                  used_in[free_idx] = 1'b1;
                  type_in[free_idx] = req_bus.action_type;
                  len_in[free_idx]  = clamped;
                  used_count_in     = used_count_ff + COUNT_W'(1);
                  fill_slot_in      = free_idx;
                  fill_pos_in       = '0;
                  fill_len_in       = clamped;
                  fill_hw_in        = hw_rd;
                  fill_active_in    = clamped != '0;
                  cmd_data.status   = ST_OK;
               end else begin
                  cmd_data.status   = ST_FULL;
               end
            end
            OP_PAYLOAD: begin
               if (fill_active_ff) begin
                  ram_wr_en      = 1'b1;
                  fill_pos_in    = pos_next;
                  fill_active_in = pos_next < fill_len_ff;
                  if (pos_next > fill_hw_ff) begin
                     fill_hw_in          = pos_next;
                     hw_in[fill_slot_ff] = pos_next;
                  end
               end
            end
            OP_DEQUEUE: begin
               cmd_push = 1'b1;
               if (used_found) begin
                  used_in[used_idx] = 1'b0;
                  used_count_in     = used_count_ff - COUNT_W'(1);
                  if (fill_active_ff && fill_slot_ff == used_idx) begin
                     fill_active_in = 1'b0;
                  end
                  cmd_data.status      = ST_OK;
                  cmd_data.action_type = type_ff[used_idx];
                  if (len_ff[used_idx] != '0) begin
                     stream_push      = 1'b1;
                     cmd_data.kind    = CMD_STREAM;
                     cmd_data.length  = len_ff[used_idx];
                     cmd_data.written = hw_rd;
                     cmd_data.slot    = used_idx;
                  end
               end else begin
                  cmd_data.status = ST_EMPTY;
               end
            end
            OP_COUNT: begin
               cmd_push            = 1'b1;
               cmd_data.status     = ST_OK;
               cmd_data.used_count = used_count_ff;
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case ({stream_push, back_status.stream_done})
         2'b10:   inflight_in = inflight_ff + INFL_W'(1);
         2'b01:   inflight_in = inflight_ff - INFL_W'(1);
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff        <= '0;
         hw_ff          <= '{default: '0};
         used_count_ff  <= '0;
         fill_slot_ff   <= '0;
         fill_pos_ff    <= '0;
         fill_len_ff    <= '0;
         fill_hw_ff     <= '0;
         fill_active_ff <= 1'b0;
         inflight_ff    <= '0;
      end else begin
         used_ff        <= used_in;
         hw_ff          <= hw_in;
         used_count_ff  <= used_count_in;
         fill_slot_ff   <= fill_slot_in;
         fill_pos_ff    <= fill_pos_in;
         fill_len_ff    <= fill_len_in;
         fill_hw_ff     <= fill_hw_in;
         fill_active_ff <= fill_active_in;
         inflight_ff    <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
      len_ff  <= len_in;
   end

   `PASS_ASSERT(a_count_tracks_used, clock, reset, $countones(used_ff) == int'(used_count_ff))
   `PASS_ASSERT(a_fill_slot_used, clock, reset, !fill_active_ff || used_ff[fill_slot_ff])

endmodule

`default_nettype wire

// ----- src/pass_back.sv -----
`default_nettype none
`include "assert_macros.svh"

module pass_back import pass_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd_data,
   output logic              cmd_pop,
   output logic              ram_rd_en,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  logic [BYTE_W-1:0] ram_rd_data,
   output back_status_type   back_status,
   pass_rsp_if.source        rsp_bus
);

   logic             busy_ff, busy_in;
   cmd_type          cur_ff, cur_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic             s1_valid_ff, s1_valid_in;
   rsp_type          s1_res_ff, s1_res_in;
   logic             s1_ram_ff, s1_ram_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic             adv, issue, is_stream, elem_last;
   cmd_type          src;
   logic [LEN_W-1:0] k;

   assign adv       = !out_valid_ff || rsp_bus.ready;
   assign src       = busy_ff ? cur_ff : cmd_data;
   assign k         = busy_ff ? k_ff : '0;
   assign issue     = adv && (busy_ff || cmd_valid);
   assign cmd_pop   = adv && !busy_ff && cmd_valid;
   assign is_stream = src.kind == CMD_STREAM;
   assign elem_last = !is_stream || (k == src.length - LEN_W'(1));

   assign ram_rd_en   = issue && is_stream;
   assign ram_rd_addr = payload_addr(src.slot, k[IDX_W-1:0]);

   always_comb begin
      busy_in                 = busy_ff;
      cur_in                  = cur_ff;
      k_in                    = k_ff;
      back_status.stream_done = 1'b0;
      if (issue && is_stream) begin
         if (elem_last) begin
            busy_in                 = 1'b0;
            back_status.stream_done = 1'b1;
         end else begin
            busy_in = 1'b1;
            cur_in  = src;
            k_in    = k + LEN_W'(1);
         end
      end
   end

   // stage one: element chosen, ram read in flight
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_res_in   = s1_res_ff;
      s1_ram_in   = s1_ram_ff;
      if (adv) begin
         s1_valid_in               = issue;
         s1_res_in                 = '0;
         s1_res_in.status          = src.status;
         s1_res_in.action_type_res = src.action_type;
         s1_res_in.last            = elem_last;
         s1_ram_in                 = 1'b0;
         if (is_stream) begin
            s1_res_in.length_res = src.length;
            s1_res_in.byte_valid = 1'b1;
            // positions never written since reset read as zero
            s1_ram_in            = k < src.written;
         end else begin
            s1_res_in.used_count = src.used_count;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (adv) begin
         out_valid_in         = s1_valid_ff;
         out_in               = s1_res_ff;
         out_in.data_byte_res = s1_ram_ff ? ram_rd_data : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      k_ff      <= k_in;
      s1_res_ff <= s1_res_in;
      s1_ram_ff <= s1_ram_in;
      out_ff    <= out_in;
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.status          = out_ff.status;
   assign rsp_bus.action_type_res = out_ff.action_type_res;
   assign rsp_bus.length_res      = out_ff.length_res;
   assign rsp_bus.data_byte_res   = out_ff.data_byte_res;
   assign rsp_bus.byte_valid      = out_ff.byte_valid;
   assign rsp_bus.used_count      = out_ff.used_count;
   assign rsp_bus.last            = out_ff.last;

   `PASS_ASSERT(a_stream_index_in_range, clock, reset, !busy_ff || k_ff < cur_ff.length)
   `PASS_ASSERT_NEXT(a_stream_continues, clock, reset, issue && is_stream && !elem_last, busy_ff)

endmodule

`default_nettype wire

// ----- src/pending_action_slot_store.sv -----
// pending action slot store: a table of SLOT_COUNT slots (16), each holding an
// action type, a payload length clamped to PAYLOAD_BYTES (64) and the payload
// bytes. a request with operation 0 (enqueue header) claims the lowest free slot
// and answers ok, or answers full; the payload bytes that follow (operation 1,
// no response) fill that slot in order up to its clamped length, further bytes
// are dropped and bytes never sent keep their old contents. operation 2
// (dequeue) frees the lowest used slot and returns its bytes one per response
// with last on the final one, a single byte_valid=0 response for a zero-length
// slot, or empty. operation 3 answers with the number of used slots. the front
// takes one request per cycle while the command queue has room; a dequeue
// streams one byte per cycle while responses are taken, paced by the single
// read port of the payload ram, and payload bytes for an open fill wait until
// any dequeue ahead of them has finished reading the ram. a response passes
// through the command queue, stage one and the output register. payload the
// table never received reads as zero through a per-slot written count, so the
// block needs no clearing pass after reset.
`default_nettype none

module pending_action_slot_store import pass_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pass_req_if.sink    req_bus,
   pass_rsp_if.source  rsp_bus
);

   // front to queue
   logic              cmd_push;
   cmd_type           cmd_push_data;
   logic              cmd_space;

   // queue to back
   logic              cmd_valid;
   cmd_type           cmd_data;
   logic              cmd_pop;

   // payload ram, written by the front and read by the back
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   // back tells the front when a stream has issued its final ram read
   back_status_type   back_status;

   // slot bookkeeping, fill tracking and classification of each request
   pass_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_push_data),
      .cmd_space   (cmd_space),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .back_status (back_status)
   );

   // short queue so front and back stall on their own
   pass_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .space     (cmd_space),
      .valid     (cmd_valid),
      .data      (cmd_data),
      .pop       (cmd_pop)
   );

   // payload bytes of every slot, one byte per entry
   pass_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SLOT_COUNT * PAYLOAD_BYTES)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // response sequencer: byte streams and single responses, output register
   pass_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .back_status (back_status),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire
